// File: design/assert_macros.svh
// Assertion macros shared by the checker RTL.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/icmp_erc_pkg.sv
// Package for the ICMP echo reply checker: widths, offsets, status codes, types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmp_erc_pkg;

    localparam int unsigned MAX_PACKET_BYTES = 2048;
    localparam int unsigned CNT_W      = $clog2(MAX_PACKET_BYTES + 1);
    localparam int unsigned LEN_W      = 12;
    localparam int unsigned CALC_W     = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned HW_W       = 4;
    localparam int unsigned ID_W       = 16;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned WORD_SHIFT = 2;

    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_PACKET_BYTES);
    localparam logic [CNT_W-1:0] OFS_PROTO  = CNT_W'(9);
    localparam logic [CNT_W-1:0] OFS_ID_LO  = CNT_W'(4);
    localparam logic [CNT_W-1:0] OFS_ID_HI  = CNT_W'(5);
    localparam logic [CNT_W-1:0] OFS_MARKER = CNT_W'(8);

    localparam logic [BYTE_W-1:0] PROTO_ICMP      = 8'd1;
    localparam logic [BYTE_W-1:0] TYPE_ECHO_REPLY = 8'd0;

    localparam logic [CALC_W-1:0] MIN_ICMP_HEADER    = CALC_W'(8);
    localparam logic [CALC_W-1:0] MIN_ICMP_WITH_DATA = CALC_W'(16);
    localparam logic [CALC_W-1:0] LEN_SAT            = CALC_W'(4095);

    localparam logic [STATUS_W-1:0] ST_OK              = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_ECHO_REPLY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_ICMP        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT_HEADER    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ID_MISMATCH     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SHORT_DATA      = 3'd5;
    localparam logic [STATUS_W-1:0] ST_MARKER_MISMATCH = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARKER_VALUE = 1'd1;

    typedef struct packed {
        logic [CNT_W-1:0]  byte_count;
        logic [HW_W-1:0]   header_words;
        logic [BYTE_W-1:0] protocol_byte;
        logic [BYTE_W-1:0] type_byte;
        logic [ID_W-1:0]   id_seen;
        logic [BYTE_W-1:0] marker_seen;
    } t_pkt_snap;

    typedef struct packed {
        logic [ID_W-1:0]   expected_id;
        logic [BYTE_W-1:0] marker_value;
    } t_cfg;

endpackage

`default_nettype wire

// File: design/icmp_erc_if.sv
// Channel interfaces: packet byte stream, verdict stream, register writes.
// Depends on icmp_erc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface icmp_erc_in_if;
    import icmp_erc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              last_byte;
    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface icmp_erc_out_if;
    import icmp_erc_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    icmp_length;
    modport source (output valid, output status, output icmp_length, input ready);
    modport sink   (input valid, input status, input icmp_length, output ready);
endinterface

interface icmp_erc_cfg_if;
    import icmp_erc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/icmp_erc_capture.sv
// Per-byte capture: byte counter, IHL and field grabs; snapshot register on last byte.
// Depends on icmp_erc_pkg, icmp_erc_if, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module icmp_erc_capture (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    icmp_erc_in_if.sink            i_in,
    output icmp_erc_pkg::t_pkt_snap o_snap,
    output logic                   o_snap_valid,
    input  wire                    i_snap_ready
);
    import icmp_erc_pkg::*;

    `include "assert_macros.svh"

    logic              in_xfer;
    logic              active;
    logic [CNT_W-1:0]  base;
    t_pkt_snap         r_pkt, n_pkt, n_upd;
    t_pkt_snap         r_snap;
    logic              r_snap_valid, n_snap_valid;

    assign i_in.ready = !r_snap_valid || i_snap_ready;
    assign in_xfer    = i_in.valid && i_in.ready;
    assign active     = (r_pkt.byte_count != CNT_MAX);

    always_comb begin
        n_upd = r_pkt;
        if (r_pkt.byte_count == '0) begin
            n_upd.header_words = i_in.byte_value[HW_W-1:0];
        end
        base = CNT_W'(n_upd.header_words) << WORD_SHIFT;
        if (active) begin
            if (r_pkt.byte_count == OFS_PROTO) begin
                n_upd.protocol_byte = i_in.byte_value;
            end
            if (r_pkt.byte_count == base) begin
                n_upd.type_byte = i_in.byte_value;
            end
            if (r_pkt.byte_count == base + OFS_ID_LO) begin
                n_upd.id_seen[BYTE_W-1:0] = i_in.byte_value;
            end
            if (r_pkt.byte_count == base + OFS_ID_HI) begin
                n_upd.id_seen[ID_W-1:BYTE_W] = i_in.byte_value;
            end
            if (r_pkt.byte_count == base + OFS_MARKER) begin
                n_upd.marker_seen = i_in.byte_value;
            end
            n_upd.byte_count = r_pkt.byte_count + CNT_W'(1);
        end else begin
            n_upd.header_words = r_pkt.header_words;
        end
    end

    always_comb begin
        n_pkt        = r_pkt;
        n_snap_valid = r_snap_valid;
        if (i_snap_ready) begin
            n_snap_valid = 1'b0;
        end
        if (in_xfer) begin
            if (i_in.last_byte) begin
                n_pkt        = '0;
                n_snap_valid = 1'b1;
            end else begin
                n_pkt = n_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt        <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            r_pkt        <= n_pkt;
            r_snap_valid <= n_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in.last_byte) begin
            r_snap <= n_upd;
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

    `CHK_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_pkt.byte_count <= CNT_MAX, "byte count past max")
    `CHK_NEXT(a_last_clears, i_clk, i_rst_n, in_xfer && i_in.last_byte, (r_pkt.byte_count == '0) && r_snap_valid, "last byte did not clear state or load snapshot")
    `CHK_NEXT(a_cnt_step, i_clk, i_rst_n, in_xfer && !i_in.last_byte && active, r_pkt.byte_count == $past(r_pkt.byte_count) + CNT_W'(1), "byte count did not advance")

endmodule

`default_nettype wire

// File: design/icmp_erc_verdict.sv
// Verdict stage: length math and ordered checks on a packet snapshot; result register.
// Depends on icmp_erc_pkg, icmp_erc_if, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

module icmp_erc_verdict (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  icmp_erc_pkg::t_pkt_snap i_snap,
    input  wire                     i_snap_valid,
    output logic                    o_snap_ready,
    input  icmp_erc_pkg::t_cfg      i_cfg,
    icmp_erc_out_if.source          o_out
);
    import icmp_erc_pkg::*;

    `include "assert_macros.svh"

    logic [CALC_W-1:0]   cnt_ext, hdr_ext, diff;
    logic                neg;
    logic [LEN_W-1:0]    shown;
    logic [STATUS_W-1:0] status;
    logic                load;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [LEN_W-1:0]    r_icmp_length;

    always_comb begin
        cnt_ext = CALC_W'(i_snap.byte_count);
        hdr_ext = CALC_W'(i_snap.header_words) << WORD_SHIFT;
        neg     = cnt_ext < hdr_ext;
        diff    = cnt_ext - hdr_ext;
        if (neg) begin
            shown = '0;
        end else if (diff > LEN_SAT) begin
            shown = LEN_W'(LEN_SAT);
        end else begin
            shown = diff[LEN_W-1:0];
        end

        if (i_snap.protocol_byte != PROTO_ICMP) begin
            status = ST_NOT_ICMP;
        end else if (neg || diff < MIN_ICMP_HEADER) begin
            status = ST_SHORT_HEADER;
        end else if (i_snap.type_byte != TYPE_ECHO_REPLY) begin
            status = ST_NOT_ECHO_REPLY;
        end else if (i_snap.id_seen != i_cfg.expected_id) begin
            status = ST_ID_MISMATCH;
        end else if (diff < MIN_ICMP_WITH_DATA) begin
            status = ST_SHORT_DATA;
        end else if (i_snap.marker_seen != i_cfg.marker_value) begin
            status = ST_MARKER_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    assign o_snap_ready = !r_out_valid || o_out.ready;
    assign load         = i_snap_valid && o_snap_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_status      <= status;
            r_icmp_length <= shown;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.icmp_length = r_icmp_length;

    `CHK_IMPLIES(a_ok_len, i_clk, i_rst_n, r_out_valid && (r_status == ST_OK), r_icmp_length >= LEN_W'(16), "ok verdict on short packet")
    `CHK_IMPLIES(a_short_data_len, i_clk, i_rst_n, r_out_valid && (r_status == ST_SHORT_DATA), (r_icmp_length >= LEN_W'(8)) && (r_icmp_length < LEN_W'(16)), "short data verdict with wrong length")
    `CHK_NEXT(a_load_shows, i_clk, i_rst_n, load, r_out_valid && (r_status == $past(status)), "snapshot verdict not registered")

endmodule

`default_nettype wire

// File: design/icmp_erc_core_top.sv
// Configuration registers: expected identifier and marker, written over the cfg channel.
// Depends on icmp_erc_pkg and icmp_erc_if.
`timescale 1ns / 1ps
`default_nettype none

module icmp_erc_cfg_regs (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    icmp_erc_cfg_if.sink        i_cfg,
    output icmp_erc_pkg::t_cfg  o_cfg
);
    import icmp_erc_pkg::*;

    logic cfg_xfer;
    t_cfg r_cfg, n_cfg;

    assign i_cfg.ready = 1'b1;
    assign cfg_xfer    = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_xfer) begin
            case (i_cfg.index)
                CFG_EXPECTED_ID:  n_cfg.expected_id  = i_cfg.data[ID_W-1:0];
                CFG_MARKER_VALUE: n_cfg.marker_value = i_cfg.data[BYTE_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: design/icmp_echo_reply_checker_core.sv
// ICMP echo reply checker, top level; one packet byte per cycle, one verdict per packet.
// Verdict path: snapshot register, then result register (two stages).
// Throughput: one byte per cycle; input stalls only with snapshot and result both held.
// Reset (i_rst_n low, synchronous) clears packet state, registers and valids.
// Depends on icmp_erc_pkg, icmp_erc_if, icmp_erc_cfg_regs, capture and verdict.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_checker_core (
    input  wire            i_clk,
    input  wire            i_rst_n,
    icmp_erc_in_if.sink    i_in,
    icmp_erc_cfg_if.sink   i_cfg,
    icmp_erc_out_if.source o_out
);
    import icmp_erc_pkg::*;

    t_cfg      cfg;
    t_pkt_snap snap;
    logic      snap_valid;
    logic      snap_ready;

    icmp_erc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    icmp_erc_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_snap       (snap),
        .o_snap_valid (snap_valid),
        .i_snap_ready (snap_ready)
    );

    icmp_erc_verdict u_verdict (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap       (snap),
        .i_snap_valid (snap_valid),
        .o_snap_ready (snap_ready),
        .i_cfg        (cfg),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// File: tb/sv/icmp_erc_verdict_checker.sv
// Verdict checker for the ICMP echo reply checker: watches the byte, register and verdict
// channels, predicts each packet verdict and compares it with the block's output.
// Depends on icmp_erc_pkg and icmp_erc_if.
`timescale 1ns / 1ps

module icmp_erc_verdict_checker (
    input  wire     i_clk,
    input  wire     i_rst_n,
    icmp_erc_in_if  i_in,
    icmp_erc_cfg_if i_cfg,
    icmp_erc_out_if i_out,
    output int      o_fail_count,
    output int      o_pending
);
    import icmp_erc_pkg::*;

    localparam int MIN_HDR_BYTES  = 8;
    localparam int MIN_DATA_BYTES = 16;
    localparam int LEN_CEILING    = 4095;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    icmp_length;
    } t_verdict;

    t_verdict          verdicts_due[$];
    int                failures;

    logic [ID_W-1:0]   want_id;
    logic [BYTE_W-1:0] want_marker;

    logic [11:0]       rx_count;
    logic [HW_W-1:0]   hdr_words;
    logic [BYTE_W-1:0] proto_got;
    logic [BYTE_W-1:0] type_got;
    logic [ID_W-1:0]   id_got;
    logic [BYTE_W-1:0] marker_got;

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH: %s at %0t", msg, $time);
        failures++;
    endtask

    task automatic clear_packet();
        rx_count   = '0;
        hdr_words  = '0;
        proto_got  = '0;
        type_got   = '0;
        id_got     = '0;
        marker_got = '0;
    endtask

    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic last);
        int       pos;
        int       base;
        int       len;
        int       shown;
        t_verdict v;
        if (int'(rx_count) < int'(MAX_PACKET_BYTES)) begin
            pos = int'(rx_count);
            if (pos == 0) begin
                hdr_words = b[HW_W-1:0];
            end
            base = int'(hdr_words) * 4;
            if (pos == 9) begin
                proto_got = b;
            end
            if (pos == base) begin
                type_got = b;
            end
            if (pos == base + 4) begin
                id_got[7:0] = b;
            end
            if (pos == base + 5) begin
                id_got[15:8] = b;
            end
            if (pos == base + 8) begin
                marker_got = b;
            end
            rx_count = rx_count + 1'b1;
        end
        if (last) begin
            base  = int'(hdr_words) * 4;
            len   = int'(rx_count) - base;
            shown = (len < 0) ? 0 : len;
            if (shown > LEN_CEILING) begin
                shown = LEN_CEILING;
            end
            if (proto_got != PROTO_ICMP) begin
                v.status = ST_NOT_ICMP;
            end else if (len < MIN_HDR_BYTES) begin
                v.status = ST_SHORT_HEADER;
            end else if (type_got != TYPE_ECHO_REPLY) begin
                v.status = ST_NOT_ECHO_REPLY;
            end else if (id_got != want_id) begin
                v.status = ST_ID_MISMATCH;
            end else if (len < MIN_DATA_BYTES) begin
                v.status = ST_SHORT_DATA;
            end else if (marker_got != want_marker) begin
                v.status = ST_MARKER_MISMATCH;
            end else begin
                v.status = ST_OK;
            end
            v.icmp_length = LEN_W'(shown);
            verdicts_due.push_back(v);
            clear_packet();
        end
    endtask

    initial begin
        failures = 0;
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_verdict v;
        if (!i_rst_n) begin
            want_id     = '0;
            want_marker = '0;
            clear_packet();
            verdicts_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (verdicts_due.size() == 0) begin
                    flag_mismatch($sformatf("verdict with none pending: status %0d length %0d",
                                            i_out.status, i_out.icmp_length));
                end else begin
                    v = verdicts_due.pop_front();
                    if (i_out.status !== v.status) begin
                        flag_mismatch($sformatf("status got %0d, want %0d",
                                                i_out.status, v.status));
                    end
                    if (i_out.icmp_length !== v.icmp_length) begin
                        flag_mismatch($sformatf("icmp_length got %0d, want %0d",
                                                i_out.icmp_length, v.icmp_length));
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_EXPECTED_ID) begin
                    want_id = i_cfg.data[ID_W-1:0];
                end else if (i_cfg.index == CFG_MARKER_VALUE) begin
                    want_marker = i_cfg.data[BYTE_W-1:0];
                end
            end
            if (i_in.valid && i_in.ready) begin
                absorb_byte(i_in.byte_value, i_in.last_byte);
            end
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= failures;
    end

endmodule

// File: tb/sv/icmp_echo_reply_checker_core_test.sv
// Top of the ICMP echo reply checker test: clock, reset, register phases, directed and
// random packet streams with paced handshakes, and the final verdict.
// Depends on icmp_erc_pkg, icmp_erc_if, icmp_echo_reply_checker_core, icmp_erc_verdict_checker.
`timescale 1ns / 1ps

module icmp_echo_reply_checker_core_test;
    import icmp_erc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BYTES   = 140;
    localparam int MIN_PACKETS   = 4;
    localparam int RANDOM_PHASES = 5;

    logic i_clk;
    logic i_rst_n;

    icmp_erc_in_if  in_ch ();
    icmp_erc_out_if out_ch ();
    icmp_erc_cfg_if cfg_ch ();

    int fail_count;
    int pending;
    int cycle_count;

    int   burst_left;
    bit   tx_free;
    bit   rx_free;
    bit   hold_req;

    logic [ID_W-1:0]   cur_id;
    logic [BYTE_W-1:0] cur_marker;
    logic [BYTE_W-1:0] frame[$];

    icmp_echo_reply_checker_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    icmp_erc_verdict_checker verdict_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    initial begin
        cycle_count = 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // verdict sink pacing; a requested hold-off blocks the output for a long stretch
    initial begin : sink_pacing
        int   streak;
        logic level;
        streak = 0;
        level  = 1'b1;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                streak = 0;
            end else begin
                if (streak == 0) begin
                    if (rx_free) begin
                        level  = 1'b1;
                        streak = 16;
                    end else begin
                        level  = ($urandom_range(0, 3) != 0);
                        streak = $urandom_range(1, 10);
                    end
                end
                out_ch.ready <= level;
                streak--;
            end
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = tx_free ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        in_ch.last_byte  <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_frame();
        int k;
        for (k = 0; k < frame.size(); k++) begin
            push_byte(frame[k], k == frame.size() - 1);
        end
    endtask

    // IPv4 header of ihl words with an ICMP header laid over it at ihl*4
    task automatic make_frame(input logic [3:0] ihl, input int total,
                              input logic [7:0] proto, input logic [7:0] typ,
                              input logic [15:0] id, input logic [7:0] mark);
        int base;
        int k;
        frame.delete();
        base = int'(ihl) * 4;
        if (total < 1) begin
            total = 1;
        end
        for (k = 0; k < total; k++) begin
            frame.push_back(8'($urandom));
        end
        frame[0] = {4'h4, ihl};
        if (total > 9) begin
            frame[9] = proto;
        end
        if (base < total) begin
            frame[base] = typ;
        end
        if (base + 4 < total) begin
            frame[base + 4] = id[7:0];
        end
        if (base + 5 < total) begin
            frame[base + 5] = id[15:8];
        end
        if (base + 8 < total) begin
            frame[base + 8] = mark;
        end
    endtask

    task automatic fill_frame(input int total, input logic [7:0] value);
        int k;
        frame.delete();
        for (k = 0; k < total; k++) begin
            frame.push_back(value);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [ID_W-1:0] id, input logic [BYTE_W-1:0] mark);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_EXPECTED_ID;
        cfg_ch.data  <= id;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.index <= CFG_MARKER_VALUE;
        cfg_ch.data  <= {8'($urandom), mark};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cur_id     = id;
        cur_marker = mark;
    endtask

    // mostly well-formed echo replies, some with one field broken, some pure noise
    task automatic random_packet();
        int          pick;
        int          icmp_len;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [7:0]  typ;
        logic [7:0]  mark;
        logic [15:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            fill_frame($urandom_range(1, 64), 8'h00);
            foreach (frame[k]) frame[k] = 8'($urandom);
        end else begin
            ihl = ($urandom_range(0, 9) < 8) ? 4'd5 : 4'($urandom_range(0, 15));
            if ($urandom_range(0, 99) < 75) begin
                icmp_len = $urandom_range(16, 48);
            end else begin
                icmp_len = $urandom_range(0, 24) - 4;
            end
            proto = PROTO_ICMP;
            typ   = TYPE_ECHO_REPLY;
            id    = cur_id;
            mark  = cur_marker;
            if (pick < 45) begin
                case ($urandom_range(0, 4))
                    0: proto = 8'($urandom);
                    1: typ = 8'($urandom);
                    2: id = id ^ (16'h0001 << $urandom_range(0, 15));
                    3: id = 16'($urandom);
                    default: mark = mark ^ 8'($urandom_range(1, 255));
                endcase
            end
            make_frame(ihl, int'(ihl) * 4 + icmp_len, proto, typ, id, mark);
        end
        send_frame();
    endtask

    task automatic directed_packets();
        make_frame(4'd5, 36, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 84, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 36, PROTO_ICMP, 8'd8, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 36, 8'd6, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 22, 8'd17, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 27, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 28, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 35, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 40, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id ^ 16'h0080, cur_marker);
        send_frame();
        make_frame(4'd5, 40, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id ^ 16'h8000, cur_marker);
        send_frame();
        make_frame(4'd5, 40, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, ~cur_marker);
        send_frame();
        make_frame(4'd5, 28, PROTO_ICMP, 8'd3, cur_id ^ 16'h0101, ~cur_marker);
        send_frame();
        make_frame(4'd15, 76, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd15, 10, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd0, 24, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd1, 24, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd2, 30, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 1, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        make_frame(4'd5, 9, PROTO_ICMP, TYPE_ECHO_REPLY, cur_id, cur_marker);
        send_frame();
        fill_frame(40, 8'h00);
        send_frame();
        fill_frame(40, 8'hFF);
        send_frame();
    endtask

    initial begin : stimulus
        int phase;
        int phase_bytes;
        int packets;
        logic [ID_W-1:0]   id_pick;
        logic [BYTE_W-1:0] mark_pick;
        burst_left = 0;
        tx_free    = 1'b1;
        rx_free    = 1'b1;
        hold_req   = 1'b0;
        cur_id     = '0;
        cur_marker = '0;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = '0;
        in_ch.last_byte  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = CFG_EXPECTED_ID;
        cfg_ch.data      = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_regs(16'hA55A, 8'h3C);
        directed_packets();
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin id_pick = 16'h0000; mark_pick = 8'h00; end
                1: begin id_pick = 16'hFFFF; mark_pick = 8'hFF; end
                default: begin id_pick = 16'($urandom); mark_pick = 8'($urandom); end
            endcase
            program_regs(id_pick, mark_pick);
            tx_free = (phase == 3);
            rx_free = (phase == 3);
            // long sink hold-off while the sender keeps offering packets
            hold_req = (phase == 2);
            phase_bytes = 0;
            packets = 0;
            while (phase_bytes < PHASE_BYTES || packets < MIN_PACKETS) begin
                random_packet();
                phase_bytes += frame.size();
                packets++;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: icmp_echo_reply_checker_core.f
+incdir+design
design/icmp_erc_pkg.sv
design/icmp_erc_if.sv
design/icmp_erc_capture.sv
design/icmp_erc_verdict.sv
design/icmp_erc_core_top.sv
design/icmp_echo_reply_checker_core.sv
tb/sv/icmp_erc_verdict_checker.sv
tb/sv/icmp_echo_reply_checker_core_test.sv
